// ----- sv/pvm_pkg.sv -----
// Package with the shared types and constants of the PCM voice mixer.
package pvm_pkg;

  localparam int unsigned Voices = 16;
  localparam int unsigned SampleWords = 65536;
  localparam int unsigned VoiceW = $clog2(Voices);
  localparam int unsigned AddrW = $clog2(SampleWords);

  localparam logic [2:0] KindLoad   = 3'd0;
  localparam logic [2:0] KindPlay   = 3'd1;
  localparam logic [2:0] KindPause  = 3'd2;
  localparam logic [2:0] KindResume = 3'd3;
  localparam logic [2:0] KindStop   = 3'd4;
  localparam logic [2:0] KindMix    = 3'd5;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusNoSlot  = 2'd1;
  localparam logic [1:0] StatusStale   = 2'd2;

  localparam logic signed [15:0] SampleMax = 16'sh7fff;
  localparam logic signed [15:0] SampleMin = -16'sh8000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] sample_address;
    logic signed [15:0] sample_value;
    logic [16:0] sample_count;
    logic        mono;
    logic        loop;
    logic [8:0]  voice_volume;
    logic [3:0]  handle_slot;
    logic [7:0]  handle_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  generation;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return SampleMax;
    if (v < -18'sd32768) return SampleMin;
    return v[15:0];
  endfunction

endpackage

// ----- sv/pvm_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface pvm_req_if;
  import pvm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pvm_rsp_if;
  import pvm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/pvm_ram.sv -----
// Generic single-port RAM with registered read.
module pvm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- sv/pvm_scaler.sv -----
// Two-step multiplier that scales a sample by the combined Q2.16 gain.
module pvm_scaler (
  input  logic               clk_i,
  input  logic               start_i,
  input  logic        [8:0]  gvol_i,
  input  logic        [8:0]  vgain_i,
  input  logic signed [15:0] sample_i,
  output logic signed [15:0] result_o
);
  import pvm_pkg::*;

  logic [17:0] gain_q;
  logic signed [15:0] sample_q;
  logic signed [34:0] prod;
  logic signed [34:0] adj;

  // The first step registers the unsigned gain and the sample; the product is formed combinationally from them.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gain_q   <= 18'(gvol_i) * 18'(vgain_i);
      sample_q <= sample_i;
    end
  end

  always_comb begin
    prod = 35'(sample_q) * $signed({1'b0, gain_q});
    // Bias negative products so the shift truncates toward zero.
    adj = prod[34] ? prod + 35'sd65535 : prod;
    if ($signed(adj[34:16]) > 19'sd32767) begin
      result_o = SampleMax;
    end else if ($signed(adj[34:16]) < -19'sd32768) begin
      result_o = SampleMin;
    end else begin
      result_o = adj[31:16];
    end
  end
endmodule

// ----- sv/pcm_voice_mixer.sv -----
// Top level of the 16-voice PCM mixer.
// Usage: requests enter on req (valid/ready); each request returns exactly one
// response on rsp. kind selects load, play, pause, resume, stop or mix.
// global_volume must be written through cfg_we_i/cfg_wdata_i only while the
// block idles; the block itself does not enforce this. A load, play or handle
// request passes through the execute state, then its response is valid. A mix
// request walks the 16 slots with one shared memory port and one multiplier:
// an idle, paused or empty slot is only visited; a voice with nothing left is
// visited and read; a mono voice goes through read, wait, multiply and
// accumulate, and a stereo voice does so for each word. Only one request is
// in flight; ready is low from acceptance until the response has been taken,
// and rises the cycle after that. A stalled response holds its value.
// Reset clears all voices, generations and sets global_volume to unity.
// The sample memory is not cleared; reading an unloaded word gives any value.
module pcm_voice_mixer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [8:0]     cfg_wdata_i,
  pvm_req_if.sink        req,
  pvm_rsp_if.source      rsp
);
  import pvm_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StExec  = 8'b00000010,
    StVisit = 8'b00000100,
    StRead  = 8'b00001000,
    StWait  = 8'b00010000,
    StMul   = 8'b00100000,
    StAcc   = 8'b01000000,
    StResp  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic [8:0] gvol_q;
  logic [VoiceW-1:0] v_q;
  logic side_q;       // 0 left word, 1 right word of a stereo voice
  logic signed [15:0] left_q, right_q;

  logic [Voices-1:0] act_q, pau_q, lop_q, mon_q;
  logic [8:0]  gain_q [Voices];
  logic [15:0] start_q [Voices];
  logic [16:0] len_q [Voices];
  logic [15:0] pos_q [Voices];
  logic [16:0] rem_q [Voices];
  logic [7:0]  gen_q [Voices];

  logic [VoiceW-1:0] free_idx;
  logic free_found;
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = Voices - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_idx = VoiceW'(i);
        free_found = 1'b1;
      end
    end
  end

  logic mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [15:0] mem_rdata;
  assign mem_we = (state_q == StExec) && (req_q.kind == KindLoad);
  assign mem_addr = (state_q == StExec) ? req_q.sample_address[AddrW-1:0]
                                        : pos_q[v_q][AddrW-1:0];

  pvm_ram #(.Width(16), .Depth(SampleWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (req_q.sample_value),
    .rdata_o (mem_rdata)
  );

  logic signed [15:0] scaled;
  pvm_scaler u_scaler (
    .clk_i    (clk_i),
    .start_i  (state_q == StWait),
    .gvol_i   (gvol_q),
    .vgain_i  (gain_q[v_q]),
    .sample_i (mem_rdata),
    .result_o (scaled)
  );

  logic [VoiceW-1:0] hs;
  logic handle_ok;
  logic play_ok;
  logic is_handle;
  assign hs = req_q.handle_slot[VoiceW-1:0];
  assign handle_ok = act_q[hs] && (gen_q[hs] == req_q.handle_generation);
  assign play_ok = (req_q.kind == KindPlay) && free_found;
  assign is_handle = (req_q.kind == KindPause) || (req_q.kind == KindResume) ||
                     (req_q.kind == KindStop);

  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StResp);
  assign rsp.data = rsp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (req.valid) state_d = StExec;
      StExec:  state_d = (req_q.kind == KindMix) ? StVisit : StResp;
      StVisit: begin
        if (act_q[v_q] && !pau_q[v_q]) begin
          state_d = StRead;
        end else if (v_q == VoiceW'(Voices - 1)) begin
          state_d = StResp;
        end
      end
      StRead: begin
        if (rem_q[v_q] == '0) begin
          state_d = (v_q == VoiceW'(Voices - 1)) ? StResp : StVisit;
        end else begin
          state_d = StWait;
        end
      end
      StWait:  state_d = StMul;
      StMul:   state_d = StAcc;
      StAcc: begin
        if (!mon_q[v_q] && !side_q && act_q[v_q]) begin
          state_d = StRead;
        end else begin
          state_d = (v_q == VoiceW'(Voices - 1)) ? StResp : StVisit;
        end
      end
      StResp:  if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      gvol_q  <= 9'd256;
      act_q   <= '0;
      pau_q   <= '0;
      lop_q   <= '0;
      mon_q   <= '0;
      for (int i = 0; i < Voices; i++) begin
        gen_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        gvol_q <= cfg_wdata_i;
      end
      case (state_q)
        StExec: begin
          case (req_q.kind)
            KindPlay: begin
              if (free_found) begin
                gen_q[free_idx] <= gen_q[free_idx] + 8'd1;
                act_q[free_idx] <= 1'b1;
                pau_q[free_idx] <= 1'b0;
                lop_q[free_idx] <= req_q.loop;
                mon_q[free_idx] <= req_q.mono;
              end
            end
            KindPause:  if (handle_ok) pau_q[hs] <= 1'b1;
            KindResume: if (handle_ok) pau_q[hs] <= 1'b0;
            KindStop: begin
              if (handle_ok) begin
                act_q[hs] <= 1'b0;
                pau_q[hs] <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        StRead: begin
          if (rem_q[v_q] == '0 && !lop_q[v_q]) begin
            act_q[v_q] <= 1'b0;
            pau_q[v_q] <= 1'b0;
          end
        end
        StWait: begin
          if (rem_q[v_q] == 17'd1 && !lop_q[v_q]) begin
            act_q[v_q] <= 1'b0;
            pau_q[v_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and per-voice data registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (req.valid) begin
          req_q <= req.data;
        end
      end
      StExec: begin
        v_q <= '0;
        side_q <= 1'b0;
        left_q <= '0;
        right_q <= '0;
        rsp_q.status <= ((req_q.kind == KindPlay) && !free_found) ? StatusNoSlot
                        : ((is_handle && !handle_ok) ? StatusStale : StatusDone);
        rsp_q.slot <= play_ok ? 4'(free_idx) : 4'd0;
        rsp_q.generation <= play_ok ? gen_q[free_idx] + 8'd1 : 8'd0;
        rsp_q.left_sample <= '0;
        rsp_q.right_sample <= '0;
        if (play_ok) begin
          gain_q[free_idx]  <= req_q.voice_volume;
          start_q[free_idx] <= req_q.sample_address;
          pos_q[free_idx]   <= req_q.sample_address;
          len_q[free_idx]   <= req_q.sample_count;
          rem_q[free_idx]   <= req_q.sample_count;
        end
      end
      StVisit: begin
        side_q <= 1'b0;
        if (!(act_q[v_q] && !pau_q[v_q]) && v_q != VoiceW'(Voices - 1)) begin
          v_q <= v_q + VoiceW'(1);
        end
      end
      StRead: begin
        if (rem_q[v_q] == '0 && v_q != VoiceW'(Voices - 1)) begin
          v_q <= v_q + VoiceW'(1);
        end
      end
      StWait: begin
        // The memory word is captured by the scaler; advance the voice now.
        if (rem_q[v_q] == 17'd1) begin
          if (lop_q[v_q]) begin
            pos_q[v_q] <= start_q[v_q];
            rem_q[v_q] <= len_q[v_q];
          end else begin
            rem_q[v_q] <= '0;
          end
        end else begin
          pos_q[v_q] <= pos_q[v_q] + 16'd1;
          rem_q[v_q] <= rem_q[v_q] - 17'd1;
        end
      end
      StAcc: begin
        if (mon_q[v_q] || !side_q) begin
          left_q <= sat16(18'(left_q) + 18'(scaled));
        end
        if (mon_q[v_q] || side_q) begin
          right_q <= sat16(18'(right_q) + 18'(scaled));
        end
        if (!mon_q[v_q] && !side_q && act_q[v_q]) begin
          side_q <= 1'b1;
        end else if (v_q != VoiceW'(Voices - 1)) begin
          v_q <= v_q + VoiceW'(1);
        end
        if (req_q.kind == KindMix) begin
          rsp_q.left_sample <= (mon_q[v_q] || !side_q)
                               ? sat16(18'(left_q) + 18'(scaled)) : left_q;
          rsp_q.right_sample <= (mon_q[v_q] || side_q)
                                ? sat16(18'(right_q) + 18'(scaled)) : right_q;
        end
      end
      default: ;
    endcase
  end
endmodule
